// ===== sv/mxhd_pkg.sv =====
// Shared types, constants and the control store of the mesh hop and die-crossing counter.
package mxhd_pkg;

  localparam int COORD_BITS_DEF = 6;
  localparam int TOTAL_BITS_DEF = 48;
  localparam int STEP_BITS      = 6;
  localparam int TREE_BITS      = 14;
  localparam int VOL_BITS       = 32;
  localparam int CFG_IDX_BITS   = 2;
  localparam int UPC_BITS       = 6;

  localparam logic [STEP_BITS-1:0] STEP_X_RST = STEP_BITS'(4);
  localparam logic [STEP_BITS-1:0] STEP_Y_RST = STEP_BITS'(4);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP_X     = 2'd0,
    CFG_STEP_Y     = 2'd1,
    CFG_SINGLE_DIE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [STEP_BITS-1:0] step_x;
    logic [STEP_BITS-1:0] step_y;
    logic                 single_die;
  } cfg_t;

  // Jump conditions: when true, go to the jump target, else fall through.
  typedef enum logic [3:0] {
    COND_NEXT        = 4'd0,
    COND_ALWAYS      = 4'd1,
    COND_WAIT_IN     = 4'd2,
    COND_MCAST       = 4'd3,
    COND_DIV_BUSY    = 4'd4,
    COND_NO_RUN      = 4'd5,
    COND_SAME_COL    = 4'd6,
    COND_NOT_LAST    = 4'd7,
    COND_OUT_BLOCKED = 4'd8
  } cond_t;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_LATCH    = 4'd1,
    ACT_CLR_UNI  = 4'd2,
    ACT_LOAD     = 4'd3,
    ACT_DIV_HI   = 4'd4,
    ACT_DIV_LO   = 4'd5,
    ACT_ACC      = 4'd6,
    ACT_MUL      = 4'd7,
    ACT_ADD      = 4'd8,
    ACT_NEWCOL   = 4'd9,
    ACT_INIT     = 4'd10,
    ACT_SET_PREV = 4'd11,
    ACT_EMIT     = 4'd12
  } act_t;

  // Operand select codes, meaning depends on the action.
  localparam logic [1:0] SPAN_UNI_X    = 2'd0;
  localparam logic [1:0] SPAN_UNI_Y    = 2'd1;
  localparam logic [1:0] SPAN_COL_Y    = 2'd2;
  localparam logic [1:0] SPAN_RUN_X    = 2'd3;
  localparam logic [1:0] ACC_UNI       = 2'd0;
  localparam logic [1:0] ACC_TREE      = 2'd1;
  localparam logic [1:0] MUL_UNI_HOP   = 2'd0;
  localparam logic [1:0] MUL_UNI_CR    = 2'd1;
  localparam logic [1:0] MUL_TREE_HOP  = 2'd2;
  localparam logic [1:0] MUL_TREE_CR   = 2'd3;
  localparam logic [1:0] ADD_ONCHIP    = 2'd0;
  localparam logic [1:0] ADD_CROSS     = 2'd1;
  localparam logic [1:0] ADD_CROSS_END = 2'd2;
  localparam logic [1:0] SEL_NONE      = 2'd0;

  localparam logic [UPC_BITS-1:0] A_IDLE    = UPC_BITS'(0);
  localparam logic [UPC_BITS-1:0] A_MCAST   = UPC_BITS'(18);
  localparam logic [UPC_BITS-1:0] A_INIT    = UPC_BITS'(27);
  localparam logic [UPC_BITS-1:0] A_PREV    = UPC_BITS'(28);
  localparam logic [UPC_BITS-1:0] A_LASTCHK = UPC_BITS'(29);
  localparam logic [UPC_BITS-1:0] A_FINISH  = UPC_BITS'(46);

  typedef struct packed {
    cond_t               cond;
    logic [UPC_BITS-1:0] jmp;
    act_t                act;
    logic [1:0]          sel;
  } uword_t;

  typedef struct packed {
    act_t       act;
    logic [1:0] sel;
    logic       idle;
  } ctrl_t;

  typedef struct packed {
    logic div_busy;
    logic mcast;
    logic in_run;
    logic same_col;
    logic last;
    logic out_blocked;
  } stat_t;

  function automatic uword_t uw(cond_t c, logic [UPC_BITS-1:0] j, act_t a, logic [1:0] s);
    uword_t w;
    w.cond = c;
    w.jmp  = j;
    w.act  = a;
    w.sel  = s;
    return w;
  endfunction

  function automatic uword_t ucode(logic [UPC_BITS-1:0] addr);
    uword_t w;
    case (addr)
      // fetch and dispatch
      6'd0:  w = uw(COND_WAIT_IN, A_IDLE, ACT_LATCH, SEL_NONE);
      6'd1:  w = uw(COND_MCAST, A_MCAST, ACT_CLR_UNI, SEL_NONE);
      // unicast: x span
      6'd2:  w = uw(COND_NEXT, A_IDLE, ACT_LOAD, SPAN_UNI_X);
      6'd3:  w = uw(COND_NEXT, A_IDLE, ACT_DIV_HI, SEL_NONE);
      6'd4:  w = uw(COND_DIV_BUSY, UPC_BITS'(4), ACT_NONE, SEL_NONE);
      6'd5:  w = uw(COND_NEXT, A_IDLE, ACT_DIV_LO, SEL_NONE);
      6'd6:  w = uw(COND_DIV_BUSY, UPC_BITS'(6), ACT_NONE, SEL_NONE);
      6'd7:  w = uw(COND_NEXT, A_IDLE, ACT_ACC, ACC_UNI);
      // unicast: y span
      6'd8:  w = uw(COND_NEXT, A_IDLE, ACT_LOAD, SPAN_UNI_Y);
      6'd9:  w = uw(COND_NEXT, A_IDLE, ACT_DIV_HI, SEL_NONE);
      6'd10: w = uw(COND_DIV_BUSY, UPC_BITS'(10), ACT_NONE, SEL_NONE);
      6'd11: w = uw(COND_NEXT, A_IDLE, ACT_DIV_LO, SEL_NONE);
      6'd12: w = uw(COND_DIV_BUSY, UPC_BITS'(12), ACT_NONE, SEL_NONE);
      6'd13: w = uw(COND_NEXT, A_IDLE, ACT_ACC, ACC_UNI);
      // unicast: scale and add
      6'd14: w = uw(COND_NEXT, A_IDLE, ACT_MUL, MUL_UNI_HOP);
      6'd15: w = uw(COND_NEXT, A_IDLE, ACT_ADD, ADD_ONCHIP);
      6'd16: w = uw(COND_NEXT, A_IDLE, ACT_MUL, MUL_UNI_CR);
      6'd17: w = uw(COND_ALWAYS, A_FINISH, ACT_ADD, ADD_CROSS);
      // multicast destination
      6'd18: w = uw(COND_NO_RUN, A_INIT, ACT_NONE, SEL_NONE);
      6'd19: w = uw(COND_SAME_COL, A_PREV, ACT_NONE, SEL_NONE);
      6'd20: w = uw(COND_NEXT, A_IDLE, ACT_LOAD, SPAN_COL_Y);
      6'd21: w = uw(COND_NEXT, A_IDLE, ACT_DIV_HI, SEL_NONE);
      6'd22: w = uw(COND_DIV_BUSY, UPC_BITS'(22), ACT_NONE, SEL_NONE);
      6'd23: w = uw(COND_NEXT, A_IDLE, ACT_DIV_LO, SEL_NONE);
      6'd24: w = uw(COND_DIV_BUSY, UPC_BITS'(24), ACT_NONE, SEL_NONE);
      6'd25: w = uw(COND_NEXT, A_IDLE, ACT_ACC, ACC_TREE);
      6'd26: w = uw(COND_ALWAYS, A_LASTCHK, ACT_NEWCOL, SEL_NONE);
      6'd27: w = uw(COND_ALWAYS, A_LASTCHK, ACT_INIT, SEL_NONE);
      6'd28: w = uw(COND_NEXT, A_IDLE, ACT_SET_PREV, SEL_NONE);
      6'd29: w = uw(COND_NOT_LAST, A_FINISH, ACT_NONE, SEL_NONE);
      // close the last column
      6'd30: w = uw(COND_NEXT, A_IDLE, ACT_LOAD, SPAN_COL_Y);
      6'd31: w = uw(COND_NEXT, A_IDLE, ACT_DIV_HI, SEL_NONE);
      6'd32: w = uw(COND_DIV_BUSY, UPC_BITS'(32), ACT_NONE, SEL_NONE);
      6'd33: w = uw(COND_NEXT, A_IDLE, ACT_DIV_LO, SEL_NONE);
      6'd34: w = uw(COND_DIV_BUSY, UPC_BITS'(34), ACT_NONE, SEL_NONE);
      6'd35: w = uw(COND_NEXT, A_IDLE, ACT_ACC, ACC_TREE);
      // x span of the tree
      6'd36: w = uw(COND_NEXT, A_IDLE, ACT_LOAD, SPAN_RUN_X);
      6'd37: w = uw(COND_NEXT, A_IDLE, ACT_DIV_HI, SEL_NONE);
      6'd38: w = uw(COND_DIV_BUSY, UPC_BITS'(38), ACT_NONE, SEL_NONE);
      6'd39: w = uw(COND_NEXT, A_IDLE, ACT_DIV_LO, SEL_NONE);
      6'd40: w = uw(COND_DIV_BUSY, UPC_BITS'(40), ACT_NONE, SEL_NONE);
      6'd41: w = uw(COND_NEXT, A_IDLE, ACT_ACC, ACC_TREE);
      6'd42: w = uw(COND_NEXT, A_IDLE, ACT_MUL, MUL_TREE_HOP);
      6'd43: w = uw(COND_NEXT, A_IDLE, ACT_ADD, ADD_ONCHIP);
      6'd44: w = uw(COND_NEXT, A_IDLE, ACT_MUL, MUL_TREE_CR);
      6'd45: w = uw(COND_NEXT, A_IDLE, ACT_ADD, ADD_CROSS_END);
      // hand over the result
      6'd46: w = uw(COND_OUT_BLOCKED, A_FINISH, ACT_EMIT, SEL_NONE);
      6'd47: w = uw(COND_ALWAYS, A_IDLE, ACT_NONE, SEL_NONE);
      default: w = uw(COND_ALWAYS, A_IDLE, ACT_NONE, SEL_NONE);
    endcase
    return w;
  endfunction

endpackage

// ===== sv/mesh_xy_hop_and_die_crossing_counter.sv =====
// Top level of the mesh XY hop and die-crossing counter.
// Keeps two saturating running totals of hop-volume on a 2D mesh of dies: on-die hops and
// die-crossing hops. Every request returns one result, the totals after that request plus a
// sticky saturated flag. A unicast request (operation 0) adds its XY Manhattan distance times
// volume; the boundaries crossed at multiples of die_step_x / die_step_y go to the crossing
// total, the rest to the on-die total. A step of zero counts no crossings. Multicast requests
// (operation 1) come as a run of destinations sorted by x then y and closed by last_dest; the
// run builds an XY tree (one x span from the source plus one y span per column) whose 14-bit
// saturating hop and crossing counts are scaled by the last request's volume. With
// single_die_mode set the tree counts no crossings. Unicast requests may sit inside a run
// without disturbing it. The block works on one request at a time under a microprogram; its
// pace is set by one shared restoring divider that yields one quotient bit per cycle, two
// quotients per span. A unicast request runs two spans through it; a multicast request runs
// one span if it closes a column and two more if it ends the run, and no span otherwise; a
// stalled output register holds the sequencer at its emit step. in_stall is low only while
// the sequencer waits for a request; a finished result waits in the output register while
// the next request is taken. Write configuration only while the block is idle; cfg_ready is
// always high and writes to an index beyond the register list are dropped.
module mesh_xy_hop_and_die_crossing_counter #(
  parameter int COORD_BITS = mxhd_pkg::COORD_BITS_DEF,
  parameter int TOTAL_BITS = mxhd_pkg::TOTAL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [COORD_BITS-1:0]             in_src_x,
  input  logic [COORD_BITS-1:0]             in_src_y,
  input  logic [COORD_BITS-1:0]             in_dest_x,
  input  logic [COORD_BITS-1:0]             in_dest_y,
  input  logic [mxhd_pkg::VOL_BITS-1:0]     in_volume,
  input  logic                              in_last_dest,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [TOTAL_BITS-1:0]             out_onchip_hops_total,
  output logic [TOTAL_BITS-1:0]             out_crossing_hops_total,
  output logic                              out_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mxhd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mxhd_pkg::STEP_BITS-1:0]    cfg_data
);

  mxhd_pkg::cfg_t  cfg_r;
  mxhd_pkg::ctrl_t ctrl;
  mxhd_pkg::stat_t stat;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_x     <= mxhd_pkg::STEP_X_RST;
      cfg_r.step_y     <= mxhd_pkg::STEP_Y_RST;
      cfg_r.single_die <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mxhd_pkg::CFG_STEP_X:     cfg_r.step_x     <= cfg_data;
        mxhd_pkg::CFG_STEP_Y:     cfg_r.step_y     <= cfg_data;
        mxhd_pkg::CFG_SINGLE_DIE: cfg_r.single_die <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // take a request only while the sequencer sits at its fetch step
  assign in_stall = !ctrl.idle;

  mxhd_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  mxhd_datapath #(
    .COORD_BITS (COORD_BITS),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .ctrl                    (ctrl),
    .cfg                     (cfg_r),
    .stat                    (stat),
    .in_valid                (in_valid),
    .in_operation            (in_operation),
    .in_src_x                (in_src_x),
    .in_src_y                (in_src_y),
    .in_dest_x               (in_dest_x),
    .in_dest_y               (in_dest_y),
    .in_volume               (in_volume),
    .in_last_dest            (in_last_dest),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_onchip_hops_total   (out_onchip_hops_total),
    .out_crossing_hops_total (out_crossing_hops_total),
    .out_saturated           (out_saturated)
  );

endmodule

// ===== sv/mxhd_divider.sv =====
// Restoring divider, one quotient bit per cycle, for coordinate by die step.
module mxhd_divider #(
  parameter int COORD_BITS = mxhd_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [COORD_BITS-1:0]          dividend,
  input  logic [mxhd_pkg::STEP_BITS-1:0] divisor,
  output logic                           busy,
  output logic [COORD_BITS-1:0]          quotient
);

  localparam int SB        = mxhd_pkg::STEP_BITS;
  localparam int CNT_BITS  = $clog2(COORD_BITS + 1);

  logic [CNT_BITS-1:0]   cnt_r;
  logic [SB-1:0]         rem_r;
  logic [SB-1:0]         div_r;
  logic [COORD_BITS-1:0] quo_r;
  logic [SB:0]           trial;
  logic [SB:0]           diff;
  logic                  ge;

  always_comb begin
    trial = {rem_r, quo_r[COORD_BITS-1]};
    diff  = trial - {1'b0, div_r};
    ge    = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_BITS'(COORD_BITS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[SB-1:0] : trial[SB-1:0];
      quo_r <= {quo_r[COORD_BITS-2:0], ge};
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

// ===== sv/mxhd_sequencer.sv =====
// Microprogram counter and control store fetch with conditional jumps.
module mxhd_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  mxhd_pkg::stat_t stat,
  output mxhd_pkg::ctrl_t ctrl
);

  localparam int UB = mxhd_pkg::UPC_BITS;

  logic [UB-1:0]    upc_r;
  logic [UB-1:0]    upc_nxt;
  mxhd_pkg::uword_t w;
  logic             take;

  always_comb begin
    w = mxhd_pkg::ucode(upc_r);
    case (w.cond)
      mxhd_pkg::COND_NEXT:        take = 1'b0;
      mxhd_pkg::COND_ALWAYS:      take = 1'b1;
      mxhd_pkg::COND_WAIT_IN:     take = !in_valid;
      mxhd_pkg::COND_MCAST:       take = stat.mcast;
      mxhd_pkg::COND_DIV_BUSY:    take = stat.div_busy;
      mxhd_pkg::COND_NO_RUN:      take = !stat.in_run;
      mxhd_pkg::COND_SAME_COL:    take = stat.same_col;
      mxhd_pkg::COND_NOT_LAST:    take = !stat.last;
      mxhd_pkg::COND_OUT_BLOCKED: take = stat.out_blocked;
      default:                    take = 1'b1;
    endcase
    upc_nxt   = take ? w.jmp : upc_r + UB'(1);
    ctrl.act  = w.act;
    ctrl.sel  = w.sel;
    ctrl.idle = (upc_r == mxhd_pkg::A_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= mxhd_pkg::A_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== sv/mxhd_datapath.sv =====
// Operand registers, span unit, tree state, multiplier and saturating totals.
module mxhd_datapath #(
  parameter int COORD_BITS = mxhd_pkg::COORD_BITS_DEF,
  parameter int TOTAL_BITS = mxhd_pkg::TOTAL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mxhd_pkg::ctrl_t               ctrl,
  input  mxhd_pkg::cfg_t                cfg,
  output mxhd_pkg::stat_t               stat,
  input  logic                          in_valid,
  input  logic                          in_operation,
  input  logic [COORD_BITS-1:0]         in_src_x,
  input  logic [COORD_BITS-1:0]         in_src_y,
  input  logic [COORD_BITS-1:0]         in_dest_x,
  input  logic [COORD_BITS-1:0]         in_dest_y,
  input  logic [mxhd_pkg::VOL_BITS-1:0] in_volume,
  input  logic                          in_last_dest,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [TOTAL_BITS-1:0]         out_onchip_hops_total,
  output logic [TOTAL_BITS-1:0]         out_crossing_hops_total,
  output logic                          out_saturated
);

  localparam int TB        = mxhd_pkg::TREE_BITS;
  localparam int VB        = mxhd_pkg::VOL_BITS;
  localparam int SB        = mxhd_pkg::STEP_BITS;
  localparam int PROD_BITS = TB + VB;
  localparam int SUM_BITS  = ((TOTAL_BITS > PROD_BITS) ? TOTAL_BITS : PROD_BITS) + 1;
  localparam logic [SUM_BITS-1:0] TOTAL_MAX = SUM_BITS'({TOTAL_BITS{1'b1}});

  // latched request
  logic                  op_r, last_r;
  logic [COORD_BITS-1:0] sx_r, sy_r, dx_r, dy_r;
  logic [VB-1:0]         vol_r;

  // multicast run state
  logic                  in_run_r, sat_r;
  logic [COORD_BITS-1:0] run_first_x_r, column_x_r, column_min_y_r, previous_y_r;
  logic [TB-1:0]         tree_hop_r, tree_cr_r, uni_hop_r, uni_cr_r;

  // span unit
  logic [COORD_BITS-1:0] lo_r, hi_r, qhi_r;
  logic [SB-1:0]         step_r;
  logic                  cr_en_r;
  logic                  div_start, div_busy;
  logic [COORD_BITS-1:0] div_q;

  // scale and totals
  logic [PROD_BITS-1:0]  prod_r;
  logic [TOTAL_BITS-1:0] onchip_r, cross_r;
  logic                  out_valid_r, out_sat_r;
  logic [TOTAL_BITS-1:0] out_onchip_r, out_cross_r;

  logic [COORD_BITS-1:0] span_lo, span_hi;
  logic [SB-1:0]         span_step;
  logic                  span_cr_en;
  logic [COORD_BITS-1:0] len, cr, hops;
  logic [TB-1:0]         acc_hop, acc_cr;
  logic [TB:0]           sum_hop, sum_cr;
  logic [TB-1:0]         mul_amt;
  logic [TOTAL_BITS-1:0] add_base;
  logic [SUM_BITS-1:0]   add_sum;
  logic                  add_ovf;
  logic [TOTAL_BITS-1:0] add_res;
  logic                  out_blocked;
  logic                  accept;

  mxhd_divider #(.COORD_BITS(COORD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ((ctrl.act == mxhd_pkg::ACT_DIV_HI) ? hi_r : lo_r),
    .divisor  (step_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign div_start = (ctrl.act == mxhd_pkg::ACT_DIV_HI) || (ctrl.act == mxhd_pkg::ACT_DIV_LO);
  assign accept    = (ctrl.act == mxhd_pkg::ACT_LATCH) && in_valid;

  // span operands: low end, high end and the step of its axis
  always_comb begin
    case (ctrl.sel)
      mxhd_pkg::SPAN_UNI_X: begin
        span_lo    = (sx_r < dx_r) ? sx_r : dx_r;
        span_hi    = (sx_r < dx_r) ? dx_r : sx_r;
        span_step  = cfg.step_x;
        span_cr_en = (cfg.step_x != '0);
      end
      mxhd_pkg::SPAN_UNI_Y: begin
        span_lo    = (sy_r < dy_r) ? sy_r : dy_r;
        span_hi    = (sy_r < dy_r) ? dy_r : sy_r;
        span_step  = cfg.step_y;
        span_cr_en = (cfg.step_y != '0);
      end
      mxhd_pkg::SPAN_COL_Y: begin
        span_lo    = (sy_r < column_min_y_r) ? sy_r : column_min_y_r;
        span_hi    = (sy_r > previous_y_r) ? sy_r : previous_y_r;
        span_step  = cfg.step_y;
        span_cr_en = !cfg.single_die && (cfg.step_y != '0);
      end
      default: begin
        span_lo    = (sx_r < run_first_x_r) ? sx_r : run_first_x_r;
        span_hi    = (sx_r > dx_r) ? sx_r : dx_r;
        span_step  = cfg.step_x;
        span_cr_en = !cfg.single_die && (cfg.step_x != '0);
      end
    endcase
  end

  // crossings = hi/step - lo/step; split the span length
  always_comb begin
    len     = hi_r - lo_r;
    cr      = cr_en_r ? (qhi_r - div_q) : '0;
    hops    = len - cr;
    acc_hop = (ctrl.sel == mxhd_pkg::ACC_TREE) ? tree_hop_r : uni_hop_r;
    acc_cr  = (ctrl.sel == mxhd_pkg::ACC_TREE) ? tree_cr_r : uni_cr_r;
    sum_hop = {1'b0, acc_hop} + (TB + 1)'(hops);
    sum_cr  = {1'b0, acc_cr} + (TB + 1)'(cr);
  end

  always_comb begin
    case (ctrl.sel)
      mxhd_pkg::MUL_UNI_HOP:  mul_amt = uni_hop_r;
      mxhd_pkg::MUL_UNI_CR:   mul_amt = uni_cr_r;
      mxhd_pkg::MUL_TREE_HOP: mul_amt = tree_hop_r;
      default:                mul_amt = tree_cr_r;
    endcase
    add_base = (ctrl.sel == mxhd_pkg::ADD_ONCHIP) ? onchip_r : cross_r;
    add_sum  = SUM_BITS'(add_base) + SUM_BITS'(prod_r);
    add_ovf  = (add_sum > TOTAL_MAX);
    add_res  = add_ovf ? {TOTAL_BITS{1'b1}} : add_sum[TOTAL_BITS-1:0];
  end

  assign out_blocked = out_valid_r && out_stall;

  // request latch and span operands
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      sx_r   <= in_src_x;
      sy_r   <= in_src_y;
      dx_r   <= in_dest_x;
      dy_r   <= in_dest_y;
      vol_r  <= in_volume;
      last_r <= in_last_dest;
    end
    if (ctrl.act == mxhd_pkg::ACT_LOAD) begin
      lo_r    <= span_lo;
      hi_r    <= span_hi;
      step_r  <= span_step;
      cr_en_r <= span_cr_en;
    end
    if (ctrl.act == mxhd_pkg::ACT_DIV_LO) begin
      qhi_r <= div_q;
    end
    if (ctrl.act == mxhd_pkg::ACT_MUL) begin
      prod_r <= PROD_BITS'(mul_amt) * PROD_BITS'(vol_r);
    end
  end

  // unicast scratch accumulators
  always_ff @(posedge clk) begin
    if (ctrl.act == mxhd_pkg::ACT_CLR_UNI) begin
      uni_hop_r <= '0;
      uni_cr_r  <= '0;
    end else if (ctrl.act == mxhd_pkg::ACT_ACC && ctrl.sel == mxhd_pkg::ACC_UNI) begin
      uni_hop_r <= sum_hop[TB-1:0];
      uni_cr_r  <= sum_cr[TB-1:0];
    end
  end

  // run state, tree counters, totals and the sticky flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r       <= 1'b0;
      sat_r          <= 1'b0;
      run_first_x_r  <= '0;
      column_x_r     <= '0;
      column_min_y_r <= '0;
      previous_y_r   <= '0;
      tree_hop_r     <= '0;
      tree_cr_r      <= '0;
      onchip_r       <= '0;
      cross_r        <= '0;
    end else begin
      case (ctrl.act)
        mxhd_pkg::ACT_INIT: begin
          in_run_r       <= 1'b1;
          run_first_x_r  <= dx_r;
          column_x_r     <= dx_r;
          column_min_y_r <= dy_r;
          previous_y_r   <= dy_r;
          tree_hop_r     <= '0;
          tree_cr_r      <= '0;
        end
        mxhd_pkg::ACT_NEWCOL: begin
          column_x_r     <= dx_r;
          column_min_y_r <= dy_r;
          previous_y_r   <= dy_r;
        end
        mxhd_pkg::ACT_SET_PREV: begin
          previous_y_r <= dy_r;
        end
        mxhd_pkg::ACT_ACC: begin
          if (ctrl.sel == mxhd_pkg::ACC_TREE) begin
            // clamp each tree counter at all ones
            tree_hop_r <= sum_hop[TB] ? {TB{1'b1}} : sum_hop[TB-1:0];
            tree_cr_r  <= sum_cr[TB] ? {TB{1'b1}} : sum_cr[TB-1:0];
            if (sum_hop[TB] || sum_cr[TB]) begin
              sat_r <= 1'b1;
            end
          end
        end
        mxhd_pkg::ACT_ADD: begin
          if (ctrl.sel == mxhd_pkg::ADD_ONCHIP) begin
            onchip_r <= add_res;
          end else begin
            cross_r <= add_res;
          end
          if (add_ovf) begin
            sat_r <= 1'b1;
          end
          if (ctrl.sel == mxhd_pkg::ADD_CROSS_END) begin
            in_run_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register: load on emit when free, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.act == mxhd_pkg::ACT_EMIT && !out_blocked) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == mxhd_pkg::ACT_EMIT && !out_blocked) begin
      out_onchip_r <= onchip_r;
      out_cross_r  <= cross_r;
      out_sat_r    <= sat_r;
    end
  end

  always_comb begin
    stat.div_busy    = div_busy;
    stat.mcast       = op_r;
    stat.in_run      = in_run_r;
    stat.same_col    = (dx_r == column_x_r);
    stat.last        = last_r;
    stat.out_blocked = out_blocked;
  end

  assign out_valid               = out_valid_r;
  assign out_onchip_hops_total   = out_onchip_r;
  assign out_crossing_hops_total = out_cross_r;
  assign out_saturated           = out_sat_r;

endmodule

// ===== tb/tb_mesh_xy_hop_and_die_crossing_counter.sv =====
// Self-checking testbench for the mesh XY hop and die-crossing counter.
`timescale 1ns / 1ps

module tb_mesh_xy_hop_and_die_crossing_counter;

  localparam int COORD_W = mxhd_pkg::COORD_BITS_DEF;
  localparam int TOTAL_W = mxhd_pkg::TOTAL_BITS_DEF;
  localparam int TREE_W  = mxhd_pkg::TREE_BITS;
  localparam int VOL_W   = mxhd_pkg::VOL_BITS;
  localparam int STEP_W  = mxhd_pkg::STEP_BITS;

  localparam int unsigned COORD_MAX = (1 << COORD_W) - 1;
  localparam int unsigned TREE_MAX  = (1 << TREE_W) - 1;
  localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;
  localparam logic [VOL_W-1:0] VOL_MAX = '1;

  // Request kinds carried on in_operation.
  localparam bit OP_UNICAST   = 1'b0;
  localparam bit OP_MULTICAST = 1'b1;

  // Index past the end of the register list; the block must drop writes to it.
  localparam logic [mxhd_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

  // Watchdog limit, in cycles, for the whole simulation.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Settle time after the drain, long enough for the longest request (a run's closing destination).
  localparam int END_SETTLE = 80;

  typedef struct packed {
    logic [TOTAL_W-1:0] onchip;
    logic [TOTAL_W-1:0] crossing;
    logic               sat;
  } tally_t;

  // Running-total predictor plus the queue of totals still owed by the block.
  class hop_ledger;
    bit [STEP_W-1:0]  step_x = mxhd_pkg::STEP_X_RST;
    bit [STEP_W-1:0]  step_y = mxhd_pkg::STEP_Y_RST;
    bit               single_die;
    bit [TOTAL_W-1:0] onchip;
    bit [TOTAL_W-1:0] crossing;
    bit [COORD_W-1:0] first_x, col_x, col_min_y, prev_y;
    bit [TREE_W-1:0]  tree_hops, tree_cross;
    bit               in_run, sat;
    tally_t           pending[$];
    int unsigned      mismatches, results_seen, unicasts, dests, runs_closed;

    function int unsigned lower(int unsigned a, int unsigned b);
      return (a < b) ? a : b;
    endfunction

    function int unsigned upper(int unsigned a, int unsigned b);
      return (a > b) ? a : b;
    endfunction

    // Die boundaries at positive multiples of step between a and b.
    function int unsigned boundaries(int unsigned a, int unsigned b, int unsigned step);
      if (step == 0) return 0;
      return upper(a, b) / step - lower(a, b) / step;
    endfunction

    function bit [TOTAL_W-1:0] add_total(bit [TOTAL_W-1:0] acc, logic [63:0] amount);
      if (amount > TOTAL_MAX - 64'(acc)) begin
        sat = 1'b1;
        return TOTAL_W'(TOTAL_MAX);
      end
      return acc + TOTAL_W'(amount);
    endfunction

    function bit [TREE_W-1:0] add_tree(bit [TREE_W-1:0] acc, int unsigned amount);
      if (amount > TREE_MAX - acc) begin
        sat = 1'b1;
        return TREE_W'(TREE_MAX);
      end
      return acc + TREE_W'(amount);
    endfunction

    function void add_span(int unsigned lo, int unsigned hi, int unsigned step);
      int unsigned len, cr;
      len = hi - lo;
      cr = single_die ? 0 : boundaries(hi, lo, step);
      tree_hops = add_tree(tree_hops, len - cr);
      tree_cross = add_tree(tree_cross, cr);
    endfunction

    // The y span of a column stretches to take in the closing request's source row.
    function void close_column(int unsigned sy);
      add_span(lower(sy, col_min_y), upper(sy, prev_y), step_y);
    endfunction

    function void set_register(logic [mxhd_pkg::CFG_IDX_BITS-1:0] idx, bit [STEP_W-1:0] data);
      case (idx)
        mxhd_pkg::CFG_STEP_X:     step_x = data;
        mxhd_pkg::CFG_STEP_Y:     step_y = data;
        mxhd_pkg::CFG_SINGLE_DIE: single_die = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(bit op, bit [COORD_W-1:0] sx, bit [COORD_W-1:0] sy,
                               bit [COORD_W-1:0] dx, bit [COORD_W-1:0] dy,
                               bit [VOL_W-1:0] vol, bit last);
      int unsigned hops, cr;
      tally_t t;
      if (op == OP_UNICAST) begin
        unicasts++;
        hops = (upper(sx, dx) - lower(sx, dx)) + (upper(sy, dy) - lower(sy, dy));
        cr = boundaries(sx, dx, step_x) + boundaries(sy, dy, step_y);
        onchip = add_total(onchip, 64'(hops - cr) * 64'(vol));
        crossing = add_total(crossing, 64'(cr) * 64'(vol));
      end else begin
        dests++;
        if (!in_run) begin
          in_run = 1'b1;
          first_x = dx;
          col_x = dx;
          col_min_y = dy;
          tree_hops = '0;
          tree_cross = '0;
        end else if (dx != col_x) begin
          close_column(sy);
          col_x = dx;
          col_min_y = dy;
        end
        prev_y = dy;
        if (last) begin
          close_column(sy);
          add_span(lower(sx, first_x), upper(sx, dx), step_x);
          onchip = add_total(onchip, 64'(tree_hops) * 64'(vol));
          crossing = add_total(crossing, 64'(tree_cross) * 64'(vol));
          in_run = 1'b0;
          runs_closed++;
        end
      end
      t.onchip = onchip;
      t.crossing = crossing;
      t.sat = sat;
      pending = {pending, t};
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] ERROR %s", $time, msg);
    endtask

    task check_result(logic [TOTAL_W-1:0] got_onchip, logic [TOTAL_W-1:0] got_crossing,
                      logic got_sat);
      tally_t t;
      results_seen++;
      if (pending.size() == 0) begin
        report("result arrived with no request outstanding");
        return;
      end
      t = pending.pop_front();
      if (got_onchip !== t.onchip)
        report($sformatf("result %0d onchip_hops_total got %0d expected %0d",
                         results_seen, got_onchip, t.onchip));
      if (got_crossing !== t.crossing)
        report($sformatf("result %0d crossing_hops_total got %0d expected %0d",
                         results_seen, got_crossing, t.crossing));
      if (got_sat !== t.sat)
        report($sformatf("result %0d saturated got %b expected %b",
                         results_seen, got_sat, t.sat));
    endtask
  endclass

  hop_ledger ledger = new();

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_operation = 1'b0;
  logic [COORD_W-1:0]                in_src_x = '0;
  logic [COORD_W-1:0]                in_src_y = '0;
  logic [COORD_W-1:0]                in_dest_x = '0;
  logic [COORD_W-1:0]                in_dest_y = '0;
  logic [VOL_W-1:0]                  in_volume = '0;
  logic                              in_last_dest = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [TOTAL_W-1:0]                out_onchip_hops_total;
  logic [TOTAL_W-1:0]                out_crossing_hops_total;
  logic                              out_saturated;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [mxhd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [STEP_W-1:0]                 cfg_data = '0;

  // Idle knobs: sender gap chance per request (percent), receiver stall chance
  // per cycle (per mille). Zero turns that side's idling off.
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_permille = 0;
  int unsigned rx_stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned cfg_writes = 0;

  mesh_xy_hop_and_die_crossing_counter uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_operation            (in_operation),
    .in_src_x                (in_src_x),
    .in_src_y                (in_src_y),
    .in_dest_x               (in_dest_x),
    .in_dest_y               (in_dest_y),
    .in_volume               (in_volume),
    .in_last_dest            (in_last_dest),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_onchip_hops_total   (out_onchip_hops_total),
    .out_crossing_hops_total (out_crossing_hops_total),
    .out_saturated           (out_saturated),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stall in random bursts, decided at the falling edge so
  // the block sees a settled out_stall at every rising edge.
  always @(negedge clk) begin
    if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_stall = 1'b1;
    end else if (rx_stall_permille != 0 && $urandom_range(0, 999) < rx_stall_permille) begin
      rx_stall_left = $urandom_range(0, 15);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Sample results at the rising edge, before the block updates its outputs.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check_result(out_onchip_hops_total, out_crossing_hops_total, out_saturated);
  end

  // Watchdog: abandon the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] ERROR watchdog expired after %0d cycles, %0d results outstanding",
               $time, cycle_count, ledger.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Hold the sender off until the block has returned every owed result.
  // Drop valid first so a stale request is never taken twice.
  task automatic drain();
    in_valid = 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register; always from an idle block.
  task automatic write_reg(logic [mxhd_pkg::CFG_IDX_BITS-1:0] idx, bit [STEP_W-1:0] data);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    ledger.set_register(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Present one request at the falling edge and hold it until taken. Valid stays
  // high afterwards so the next request can follow back to back.
  task automatic send_request(bit op, bit [COORD_W-1:0] sx, bit [COORD_W-1:0] sy,
                              bit [COORD_W-1:0] dx, bit [COORD_W-1:0] dy,
                              bit [VOL_W-1:0] vol, bit last);
    int unsigned gap;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 16);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation = op;
    in_src_x = sx;
    in_src_y = sy;
    in_dest_x = dx;
    in_dest_y = dy;
    in_volume = vol;
    in_last_dest = last;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    ledger.note_request(op, sx, sy, dx, dy, vol, last);
    requests_sent++;
    @(negedge clk);
  endtask

  // Mix zero, all-ones, small, top-heavy and uniform volumes.
  function automatic bit [VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return VOL_MAX;
      2, 3:    return VOL_W'($urandom_range(0, 255));
      4, 5, 6: return VOL_W'(32'h8000_0000 | $urandom());
      default: return VOL_W'($urandom());
    endcase
  endfunction

  // Zero step is legal in the field and means no crossings on that axis.
  function automatic bit [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return STEP_W'(1);
      2:       return STEP_W'(COORD_MAX);
      3, 4:    return STEP_W'($urandom_range(2, 8));
      default: return STEP_W'($urandom_range(1, COORD_MAX));
    endcase
  endfunction

  task automatic random_unicast();
    send_request(OP_UNICAST, COORD_W'($urandom_range(0, COORD_MAX)),
                 COORD_W'($urandom_range(0, COORD_MAX)),
                 COORD_W'($urandom_range(0, COORD_MAX)),
                 COORD_W'($urandom_range(0, COORD_MAX)),
                 pick_volume(), 1'($urandom_range(0, 1)));
  endtask

  // Well-formed multicast: columns ascending in x, rows ascending in y, one
  // source, last_dest on the final destination. Sprinkle unicasts inside.
  task automatic sorted_run();
    int unsigned sx, sy, x, y, ncols, nrows, c, r;
    int unsigned xs[$];
    int unsigned ys[$];
    sx = $urandom_range(0, COORD_MAX);
    sy = $urandom_range(0, COORD_MAX);
    ncols = $urandom_range(1, 4);
    x = $urandom_range(0, COORD_MAX);
    xs = {xs, x};
    while (xs.size() < ncols) begin
      x += $urandom_range(1, 20);
      if (x > COORD_MAX) break;
      xs = {xs, x};
    end
    for (c = 0; c < xs.size(); c++) begin
      ys.delete();
      nrows = $urandom_range(1, 3);
      y = $urandom_range(0, COORD_MAX);
      ys = {ys, y};
      while (ys.size() < nrows) begin
        y += $urandom_range(1, 25);
        if (y > COORD_MAX) break;
        ys = {ys, y};
      end
      for (r = 0; r < ys.size(); r++) begin
        if ($urandom_range(0, 9) == 0) random_unicast();
        send_request(OP_MULTICAST, COORD_W'(sx), COORD_W'(sy), COORD_W'(xs[c]),
                     COORD_W'(ys[r]), pick_volume(),
                     (c == xs.size() - 1) && (r == ys.size() - 1));
      end
    end
  endtask

  // Unsorted or unterminated destinations with a fresh source on each one.
  task automatic broken_run();
    int unsigned n, i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++)
      send_request(OP_MULTICAST, COORD_W'($urandom_range(0, COORD_MAX)),
                   COORD_W'($urandom_range(0, COORD_MAX)),
                   COORD_W'($urandom_range(0, COORD_MAX)),
                   COORD_W'($urandom_range(0, COORD_MAX)), pick_volume(),
                   (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0));
  endtask

  initial begin
    int unsigned phase, phase_end, guard, i;

    // Hold reset, then release at a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset steps of 4, unicasts including full-mesh spans.
    send_request(OP_UNICAST, 0, 0, 63, 63, VOL_MAX, 1'b0);
    send_request(OP_UNICAST, 63, 63, 0, 0, '0, 1'b1);
    send_request(OP_UNICAST, 5, 5, 5, 5, 1, 1'b0);
    send_request(OP_UNICAST, 3, 4, 4, 3, 32'h8000_0000, 1'b0);
    // Sorted run over two columns.
    send_request(OP_MULTICAST, 10, 2, 12, 1, 32'h0000_0100, 1'b0);
    send_request(OP_MULTICAST, 10, 2, 12, 6, 32'h0000_0200, 1'b0);
    send_request(OP_MULTICAST, 10, 2, 20, 0, 32'h0000_0300, 1'b0);
    send_request(OP_MULTICAST, 10, 2, 20, 9, 32'h1234_5678, 1'b1);
    // Run of a single destination.
    send_request(OP_MULTICAST, 63, 0, 0, 63, 32'h7FFF_FFFF, 1'b1);
    // Unicast sitting inside an open run.
    send_request(OP_MULTICAST, 30, 5, 30, 5, 32'hDEAD_BEEF, 1'b0);
    send_request(OP_UNICAST, 1, 62, 62, 1, 1000, 1'b0);
    send_request(OP_MULTICAST, 30, 5, 33, 7, 3, 1'b1);
    // Unsorted run with a different source on each destination.
    send_request(OP_MULTICAST, 7, 60, 40, 50, 32'h0F0F_0F0F, 1'b0);
    send_request(OP_MULTICAST, 2, 1, 10, 3, 32'hF0F0_F0F0, 1'b0);
    send_request(OP_MULTICAST, 50, 9, 40, 2, VOL_MAX, 1'b1);

    // Zero steps, single-die trees, and a write the block must ignore.
    write_reg(mxhd_pkg::CFG_STEP_X, '0);
    write_reg(mxhd_pkg::CFG_STEP_Y, '0);
    write_reg(mxhd_pkg::CFG_SINGLE_DIE, STEP_W'(1));
    write_reg(CFG_UNUSED_IDX, STEP_W'(COORD_MAX));
    send_request(OP_UNICAST, 0, 0, 63, 63, VOL_MAX, 1'b0);
    send_request(OP_MULTICAST, 0, 0, 5, 5, 32'h0000_0001, 1'b0);
    send_request(OP_MULTICAST, 0, 0, 9, 63, VOL_MAX, 1'b1);

    // Widest dies.
    write_reg(mxhd_pkg::CFG_STEP_X, STEP_W'(COORD_MAX));
    write_reg(mxhd_pkg::CFG_STEP_Y, STEP_W'(COORD_MAX));
    write_reg(mxhd_pkg::CFG_SINGLE_DIE, '0);
    send_request(OP_UNICAST, 0, 0, 63, 63, 32'h5555_5555, 1'b1);
    send_request(OP_MULTICAST, 0, 63, 63, 0, 32'h0000_0010, 1'b0);
    send_request(OP_MULTICAST, 0, 63, 63, 63, 32'h0000_0020, 1'b1);

    // Every hop a crossing.
    write_reg(mxhd_pkg::CFG_STEP_X, STEP_W'(1));
    write_reg(mxhd_pkg::CFG_STEP_Y, STEP_W'(1));
    send_request(OP_UNICAST, 0, 63, 63, 0, 32'hAAAA_AAAA, 1'b0);
    send_request(OP_MULTICAST, 63, 63, 0, 0, 32'h0000_0040, 1'b0);
    send_request(OP_MULTICAST, 63, 63, 63, 0, VOL_MAX, 1'b1);

    // Random phases: new register values each phase, idling varied per phase
    // with the first phase and every third one running flat out.
    for (phase = 0; phase < 7; phase++) begin
      write_reg(mxhd_pkg::CFG_STEP_X, pick_step());
      write_reg(mxhd_pkg::CFG_STEP_Y, pick_step());
      write_reg(mxhd_pkg::CFG_SINGLE_DIE, STEP_W'($urandom_range(0, 3) == 0));
      if (phase % 3 == 0) begin
        tx_gap_pct = 0;
        rx_stall_permille = 0;
      end else begin
        tx_gap_pct = $urandom_range(10, 60);
        rx_stall_permille = $urandom_range(20, 150);
      end
      phase_end = requests_sent + 35;
      while (requests_sent < phase_end) begin
        // Now and then wait for the block to empty before sending more.
        if ($urandom_range(0, 49) == 0) drain();
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: random_unicast();
          17, 18, 19:          broken_run();
          default:             sorted_run();
        endcase
      end
    end

    // Last part: no idling. Drive the counters into saturation, which sets
    // the sticky flag for the rest of the run.
    tx_gap_pct = 0;
    rx_stall_permille = 0;
    write_reg(mxhd_pkg::CFG_SINGLE_DIE, STEP_W'(1));
    // Alternate columns so each destination closes a full-height column and
    // the tree hop counter overflows well before the run ends.
    for (i = 0; i < 300; i++)
      send_request(OP_MULTICAST, 63, 63, COORD_W'((i % 2) ? 63 : 0), 0,
                   (i == 299) ? VOL_MAX : VOL_W'($urandom()), i == 299);

    // Zero steps put every unicast hop on-die: fill the on-die total.
    write_reg(mxhd_pkg::CFG_STEP_X, '0);
    write_reg(mxhd_pkg::CFG_STEP_Y, '0);
    guard = 0;
    while (64'(ledger.onchip) != TOTAL_MAX && guard < 600) begin
      send_request(OP_UNICAST, COORD_W'((guard % 2) ? 63 : 0), COORD_W'((guard % 2) ? 63 : 0),
                   COORD_W'((guard % 2) ? 0 : 63), COORD_W'((guard % 2) ? 0 : 63),
                   VOL_MAX, 1'b0);
      guard++;
    end

    // Unit steps make every hop a crossing: fill the crossing total.
    write_reg(mxhd_pkg::CFG_STEP_X, STEP_W'(1));
    write_reg(mxhd_pkg::CFG_STEP_Y, STEP_W'(1));
    guard = 0;
    while (64'(ledger.crossing) != TOTAL_MAX && guard < 600) begin
      send_request(OP_UNICAST, 0, 63, 63, 0, VOL_MAX, 1'b0);
      guard++;
    end

    // Collect the rest, then give a stray result time to show up.
    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (ledger.pending.size() != 0)
      ledger.report($sformatf("%0d results never arrived", ledger.pending.size()));

    $display("Sent %0d requests: %0d unicast, %0d multicast destinations, %0d trees closed.",
             requests_sent, ledger.unicasts, ledger.dests, ledger.runs_closed);
    $display("Made %0d register writes and compared %0d results, %0d mismatches.",
             cfg_writes, ledger.results_seen, ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
